[sv/assert_macros.svh]
// assertion macros used by the quaternion unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge once out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/qq15_pkg.sv]
// package for the q1.15 quaternion unit: types, command codes and fixed-point helpers
`timescale 1ns / 1ps
package qq15_pkg;

  localparam int unsigned FracWidth = 16;

  typedef logic signed [FracWidth-1:0] word_t;

  typedef enum logic [1:0] {
    CmdMul    = 2'd0,
    CmdRotate = 2'd1,
    CmdNorm   = 2'd2,
    CmdError  = 2'd3
  } cmd_e;

  typedef struct packed {
    word_t w;
    word_t x;
    word_t y;
    word_t z;
  } quat_t;

  // floor(p*q / 2^15) wrapped to a word
  function automatic word_t fmul(word_t p, word_t q);
    logic signed [2*FracWidth-1:0] prod;
    prod = p * q;
    return prod[2*FracWidth-2:FracWidth-1];
  endfunction

  // hamilton product q*p
  function automatic quat_t qprod(quat_t q, quat_t p);
    quat_t s;
    s.w = fmul(q.w, p.w) - fmul(q.x, p.x) - fmul(q.y, p.y) - fmul(q.z, p.z);
    s.x = fmul(p.w, q.x) + fmul(p.x, q.w) - fmul(p.y, q.z) + fmul(p.z, q.y);
    s.y = fmul(p.w, q.y) + fmul(p.x, q.z) + fmul(p.y, q.w) - fmul(p.z, q.x);
    s.z = fmul(p.w, q.z) - fmul(p.x, q.y) + fmul(p.y, q.x) + fmul(p.z, q.w);
    return s;
  endfunction

  function automatic quat_t qconj(quat_t q);
    quat_t s;
    s.w = q.w;
    s.x = -q.x;
    s.y = -q.y;
    s.z = -q.z;
    return s;
  endfunction

endpackage

[sv/quaternion_q15_unit.sv]
// top level of the q1.15 quaternion unit: four-stage pipeline with valid/ready channels
// Q1.15 quaternion unit. Takes a command (multiply, rotate vector, renormalize,
// attitude error) and two quaternions, returns one quaternion. Fully pipelined:
// one word accepted per cycle while in_ready_o is high, through four register stages
// (first product, second product or error term, final scaling, output register),
// the first of which loads at the accepting edge. A stall arises only when the
// output register is full and not taken; it holds each full stage with no bubble
// ahead of it, so bubbles are squeezed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module quaternion_q15_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic signed [15:0] a_w_i,
  input  logic signed [15:0] a_x_i,
  input  logic signed [15:0] a_y_i,
  input  logic signed [15:0] a_z_i,
  input  logic signed [15:0] b_w_i,
  input  logic signed [15:0] b_x_i,
  input  logic signed [15:0] b_y_i,
  input  logic signed [15:0] b_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] r_w_o,
  output logic signed [15:0] r_x_o,
  output logic signed [15:0] r_y_o,
  output logic signed [15:0] r_z_o
);

  localparam int unsigned W = qq15_pkg::FracWidth;

  qq15_pkg::cmd_e cmd_in;
  qq15_pkg::quat_t a_in, b_in;

  // stage registers
  logic v1_q, v2_q, v3_q, v4_q;
  qq15_pkg::cmd_e c1_q, c2_q, c3_q;
  qq15_pkg::quat_t a1_q, a2_q, u1_q, u2_q, r4_q;
  logic [2*W+1:0] s1_q;
  qq15_pkg::word_t err2_q;

  logic en4, en3, en2, en1;
  assign en4 = !v4_q || out_ready_i;
  assign en3 = en4 || !v3_q;
  assign en2 = en3 || !v2_q;
  assign en1 = en2 || !v1_q;
  assign in_ready_o = en1;

  always_comb begin
    cmd_in = qq15_pkg::cmd_e'(command_i);
    a_in = '{w: a_w_i, x: a_x_i, y: a_y_i, z: a_z_i};
    b_in = '{w: b_w_i, x: b_x_i, y: b_y_i, z: b_z_i};
  end

  // stage 1: first product and squared norm
  qq15_pkg::quat_t u1_d, vq;
  logic [2*W-1:0] sq_w, sq_x, sq_y, sq_z;
  logic [2*W+1:0] s1_d;
  always_comb begin
    vq = '{w: '0, x: b_x_i, y: b_y_i, z: b_z_i};
    case (cmd_in)
      qq15_pkg::CmdMul:    u1_d = qq15_pkg::qprod(a_in, b_in);
      qq15_pkg::CmdRotate: u1_d = qq15_pkg::qprod(vq, qq15_pkg::qconj(a_in));
      qq15_pkg::CmdError:  u1_d = qq15_pkg::qprod(qq15_pkg::qconj(b_in), a_in);
      default:             u1_d = '0;
    endcase
    sq_w = $unsigned((2*W)'(a_w_i) * (2*W)'(a_w_i));
    sq_x = $unsigned((2*W)'(a_x_i) * (2*W)'(a_x_i));
    sq_y = $unsigned((2*W)'(a_y_i) * (2*W)'(a_y_i));
    sq_z = $unsigned((2*W)'(a_z_i) * (2*W)'(a_z_i));
    s1_d = {2'b00, sq_w} + {2'b00, sq_x} + {2'b00, sq_y} + {2'b00, sq_z};
  end

  // stage 2: second product or error term
  qq15_pkg::quat_t u2_d;
  logic [2*W:0] h;
  qq15_pkg::word_t sat, err_d;
  always_comb begin
    u2_d = u1_q;
    if (c1_q == qq15_pkg::CmdRotate) begin
      u2_d = qq15_pkg::qprod(a1_q, u1_q);
    end
    h = s1_q[2*W+1:1];
    if (h >= ((2*W+1)'(1) << (2*W-2))) begin
      sat = W'((1 << (W-1)) - 1);
    end else begin
      sat = W'(h >> (W-1));
    end
    err_d = W'(1 << (W-2)) - sat;
  end

  // stage 3: final scaling
  qq15_pkg::quat_t r3_d;
  always_comb begin
    case (c2_q)
      qq15_pkg::CmdMul: r3_d = u2_q;
      qq15_pkg::CmdRotate: r3_d = '{w: '0, x: u2_q.x, y: u2_q.y, z: u2_q.z};
      qq15_pkg::CmdNorm: begin
        r3_d.w = a2_q.w + qq15_pkg::fmul(a2_q.w, err2_q);
        r3_d.x = a2_q.x + qq15_pkg::fmul(a2_q.x, err2_q);
        r3_d.y = a2_q.y + qq15_pkg::fmul(a2_q.y, err2_q);
        r3_d.z = a2_q.z + qq15_pkg::fmul(a2_q.z, err2_q);
      end
      default: begin
        r3_d.w = '0;
        r3_d.x = qq15_pkg::fmul(u2_q.x, u2_q.w);
        r3_d.y = qq15_pkg::fmul(u2_q.y, u2_q.w);
        r3_d.z = qq15_pkg::fmul(u2_q.z, u2_q.w);
      end
    endcase
  end

  qq15_pkg::quat_t r3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      c1_q <= cmd_in;
      a1_q <= a_in;
      u1_q <= u1_d;
      s1_q <= s1_d;
    end
    if (en2) begin
      c2_q <= c1_q;
      a2_q <= a1_q;
      u2_q <= u2_d;
      err2_q <= err_d;
    end
    if (en3) begin
      c3_q <= c2_q;
      r3_q <= r3_d;
    end
    if (en4) begin
      r4_q <= r3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign r_w_o = r4_q.w;
  assign r_x_o = r4_q.x;
  assign r_y_o = r4_q.y;
  assign r_z_o = r4_q.z;

  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(r4_q),
               "stalled output word changed")
  `ASSERT_ALWAYS(a_ready_free, !v4_q -> in_ready_o, "input blocked with empty output")
  `ASSERT_NEXT(a_stage_move, v3_q && en4, v4_q, "word lost between stages")
  `ASSERT_ALWAYS(a_rot_w, !(v3_q && c3_q == qq15_pkg::CmdRotate) || r3_q.w == '0,
                 "rotate result has nonzero w")

endmodule

[sim/quaternion_q15_unit_checker.sv]
// checker for the q1.15 quaternion unit: predicts each result word and compares it
`timescale 1ns / 1ps
module quaternion_q15_unit_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         command_i,
  input  logic signed [15:0] a_w_i,
  input  logic signed [15:0] a_x_i,
  input  logic signed [15:0] a_y_i,
  input  logic signed [15:0] a_z_i,
  input  logic signed [15:0] b_w_i,
  input  logic signed [15:0] b_x_i,
  input  logic signed [15:0] b_y_i,
  input  logic signed [15:0] b_z_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [15:0] r_w_i,
  input  logic signed [15:0] r_x_i,
  input  logic signed [15:0] r_y_i,
  input  logic signed [15:0] r_z_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef logic signed [15:0] q15_t;

  typedef struct {
    q15_t w;
    q15_t x;
    q15_t y;
    q15_t z;
  } quat_s;

  quat_s expected_q[$];

  function automatic q15_t q15_mul(q15_t p, q15_t q);
    logic signed [31:0] prod;
    prod = 32'(p) * 32'(q);
    return q15_t'(prod >>> 15);
  endfunction

  function automatic quat_s hamilton(quat_s q, quat_s p);
    quat_s s;
    s.w = q15_mul(q.w, p.w) - q15_mul(q.x, p.x) - q15_mul(q.y, p.y) - q15_mul(q.z, p.z);
    s.x = q15_mul(p.w, q.x) + q15_mul(p.x, q.w) - q15_mul(p.y, q.z) + q15_mul(p.z, q.y);
    s.y = q15_mul(p.w, q.y) + q15_mul(p.x, q.z) + q15_mul(p.y, q.w) - q15_mul(p.z, q.x);
    s.z = q15_mul(p.w, q.z) - q15_mul(p.x, q.y) + q15_mul(p.y, q.x) + q15_mul(p.z, q.w);
    return s;
  endfunction

  function automatic quat_s conjugate(quat_s q);
    quat_s s;
    s.w = q.w;
    s.x = -q.x;
    s.y = -q.y;
    s.z = -q.z;
    return s;
  endfunction

  function automatic quat_s quat_result(qq15_pkg::cmd_e cmd, quat_s a, quat_s b);
    quat_s r;
    quat_s u;
    logic [63:0] sum;
    logic [63:0] half;
    q15_t sat;
    q15_t err;
    case (cmd)
      qq15_pkg::CmdMul: begin
        r = hamilton(a, b);
      end
      qq15_pkg::CmdRotate: begin
        b.w = '0;
        u = hamilton(b, conjugate(a));
        r = hamilton(a, u);
        r.w = '0;
      end
      qq15_pkg::CmdNorm: begin
        sum = 64'(32'(a.w) * 32'(a.w)) + 64'(32'(a.x) * 32'(a.x))
            + 64'(32'(a.y) * 32'(a.y)) + 64'(32'(a.z) * 32'(a.z));
        half = sum >> 1;
        if (half >= (64'd1 << 30)) sat = 16'sd32767;
        else sat = q15_t'(half >> 15);
        err = 16'sd16384 - sat;
        r.w = a.w + q15_mul(a.w, err);
        r.x = a.x + q15_mul(a.x, err);
        r.y = a.y + q15_mul(a.y, err);
        r.z = a.z + q15_mul(a.z, err);
      end
      default: begin
        u = hamilton(conjugate(b), a);
        r.w = '0;
        r.x = q15_mul(u.x, u.w);
        r.y = q15_mul(u.y, u.w);
        r.z = q15_mul(u.z, u.w);
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, q15_t got, q15_t want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    quat_s a;
    quat_s b;
    quat_s e;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        a = '{a_w_i, a_x_i, a_y_i, a_z_i};
        b = '{b_w_i, b_x_i, b_y_i, b_z_i};
        expected_q.push_back(quat_result(qq15_pkg::cmd_e'(command_i), a, b));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("unexpected result word at %0t", $realtime);
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          if (r_w_i !== e.w) report_mismatch("r_w", r_w_i, e.w);
          if (r_x_i !== e.x) report_mismatch("r_x", r_x_i, e.x);
          if (r_y_i !== e.y) report_mismatch("r_y", r_y_i, e.y);
          if (r_z_i !== e.z) report_mismatch("r_z", r_z_i, e.z);
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

[sim/quaternion_q15_unit_tb.sv]
// testbench top for the q1.15 quaternion unit: stimulus, idling phases and verdict
`timescale 1ns / 1ps
module quaternion_q15_unit_tb;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         command_i = qq15_pkg::CmdMul;
  logic signed [15:0] a_w_i = '0, a_x_i = '0, a_y_i = '0, a_z_i = '0;
  logic signed [15:0] b_w_i = '0, b_x_i = '0, b_y_i = '0, b_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] r_w_o, r_x_o, r_y_o, r_z_o;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 hold_cycles = 0;
  longint             cycle_count = 0;

  always #10 clk_i = ~clk_i;

  quaternion_q15_unit dut (.*);

  quaternion_q15_unit_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .command_i,
    .a_w_i, .a_x_i, .a_y_i, .a_z_i, .b_w_i, .b_x_i, .b_y_i, .b_z_i,
    .out_valid_i(out_valid_o), .out_ready_i, .r_w_i(r_w_o), .r_x_i(r_x_o),
    .r_y_i(r_y_o), .r_z_i(r_z_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic signed [15:0] pick_part();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      4: return 16'(16'sh4000 + $signed(16'($urandom_range(255))) - 16'sd128);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(logic [1:0] cmd, logic signed [15:0] aw, ax, ay, az,
                           logic signed [15:0] bw, bx, by, bz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    command_i <= cmd;
    a_w_i <= aw; a_x_i <= ax; a_y_i <= ay; a_z_i <= az;
    b_w_i <= bw; b_x_i <= bx; b_y_i <= by; b_z_i <= bz;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_random(int count);
    logic signed [15:0] p [8];
    for (int n = 0; n < count; n++) begin
      foreach (p[k]) p[k] = pick_part();
      send_word(2'($urandom_range(3)), p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int c = 0; c < 4; c++) begin
      send_word(c[1:0], 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
      send_word(c[1:0], 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_word(c[1:0], 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
                16'shffff, 16'shffff, 16'shffff, 16'shffff);
      send_word(c[1:0], 16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000,
                16'sh1234, 16'sh4000, 16'shc000, 16'sh2000);
      send_word(c[1:0], 16'sh5a82, 16'sh5a82, 16'sh0000, 16'sh0000,
                16'sh5a82, 16'sh0000, 16'sh5a82, 16'sh0000);
    end
    send_word(qq15_pkg::CmdNorm, 16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000,
              '0, '0, '0, '0);

    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(200);
    send_idle_pct = 66; recv_stall_pct = 0;  send_random(150);
    send_idle_pct = 0;  recv_stall_pct = 66; send_random(150);
    send_idle_pct = 31; recv_stall_pct = 31; send_random(150);
    send_idle_pct = 0;  recv_stall_pct = 0;
    hold_cycles = 60;
    send_random(200);
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[quaternion_q15_unit.f]
+incdir+sv
sv/qq15_pkg.sv
sv/quaternion_q15_unit.sv
sim/quaternion_q15_unit_checker.sv
sim/quaternion_q15_unit_tb.sv
